// File: src/xtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtl_pkg: shared types for the XML token lexer
// Token and error codes, scan modes, the result beat and the push bundle
// that moves the results of one text byte into the result queue.
// ----------------------------------------------------------------------------
package xtl_pkg;

  // Width of every position-like result field
  localparam int FIELD_W = 24;
  // Most results one text byte can cause
  localparam int MAX_RES = 3;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  typedef enum logic [3:0] {
    TK_LT     = 4'd0,
    TK_GT     = 4'd1,
    TK_BANG   = 4'd2,
    TK_QUEST  = 4'd3,
    TK_DASH   = 4'd4,
    TK_SLASH  = 4'd5,
    TK_EQ     = 4'd6,
    TK_IDENT  = 4'd7,
    TK_STRING = 4'd8,
    TK_NUMBER = 4'd9,
    TK_ERROR  = 4'd10,
    TK_END    = 4'd11
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNEXPECTED   = 2'd1,
    ERR_UNTERMINATED = 2'd2
  } err_kind_t;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_IDENT = 4'd1,
    M_ZERO  = 4'd2,
    M_DEC   = 4'd3,
    M_HEX   = 4'd4,
    M_DOT   = 4'd5,
    M_FRAC  = 4'd6,
    M_STR   = 4'd7,
    M_ESC   = 4'd8
  } mode_t;

  typedef struct packed {
    token_kind_t          token_kind;
    err_kind_t            error_kind;
    logic [FIELD_W-1:0]   start_offset;
    logic [FIELD_W-1:0]   token_length;
    logic [FIELD_W-1:0]   line_number;
    logic [FIELD_W-1:0]   column_number;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic                          valid;
    logic [RES_CNT_W-1:0]          cnt;
    result_t [MAX_RES-1:0]         items;
  } push_t;

endpackage

// File: src/xtl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtl_in_if: text byte channel
// One text byte per beat; a zero byte ends the text.
// ----------------------------------------------------------------------------
interface xtl_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// File: src/xtl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtl_out_if: token channel
// One token per beat with kind, error code, offset, length and position.
// ----------------------------------------------------------------------------
interface xtl_out_if import xtl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [1:0]         error_kind;
  logic [FIELD_W-1:0] start_offset;
  logic [FIELD_W-1:0] token_length;
  logic [FIELD_W-1:0] line_number;
  logic [FIELD_W-1:0] column_number;
  logic               last;

  modport source (output valid, output token_kind, output error_kind,
                  output start_offset, output token_length, output line_number,
                  output column_number, output last, input ready);
  modport sink (input valid, input token_kind, input error_kind,
                input start_offset, input token_length, input line_number,
                input column_number, input last, output ready);
endinterface

// File: src/xtl_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtl_in_stage: input byte register
// Holds one accepted text byte until the scanner consumes it; refills in
// the same cycle the held byte is taken.
// ----------------------------------------------------------------------------
module xtl_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  xtl_in_if.sink      in_if,
  input  logic        take,
  output logic        byte_valid,
  output logic [7:0]  byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_if.ready = !valid_r || take;
  assign byte_valid  = valid_r;
  assign byte_data   = byte_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.text_byte;
    end
  end

endmodule

// File: src/xtl_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtl_scanner: lexer state machine
// Classifies one text byte per cycle against the scan mode while the result
// queue has room, updates position counters and produces up to three tokens.
// ----------------------------------------------------------------------------
module xtl_scanner import xtl_pkg::*; #(
  parameter int PW = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  byte_data,
  input  logic [2:0]  free_slots,
  output logic        take,
  output push_t       push
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_HIGH  = 8'h80;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic ident_start(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == 8'h3A || c == 8'h5F || c >= CH_HIGH;
  endfunction

  function automatic logic ident_body(input logic [7:0] c);
    return ident_start(c) || c == CH_DASH || c == CH_DOT || is_digit(c);
  endfunction

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [PW-1:0] sub0(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  function automatic result_t mk(input token_kind_t k, input err_kind_t e,
                                 input logic [PW-1:0] s, input logic [PW-1:0] l,
                                 input logic [PW-1:0] ln, input logic [PW-1:0] c);
    result_t r;
    r.token_kind    = k;
    r.error_kind    = e;
    r.start_offset  = FIELD_W'(s);
    r.token_length  = FIELD_W'(l);
    r.line_number   = FIELD_W'(ln);
    r.column_number = FIELD_W'(c);
    r.last          = 1'b0;
    return r;
  endfunction

  mode_t           mode_r, mode_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [PW-1:0]   line_r, line_nxt;
  logic [PW-1:0]   lstart_r, lstart_nxt;
  logic [PW-1:0]   tstart_r, tstart_nxt;
  logic [PW-1:0]   tline_r, tline_nxt;
  logic [PW-1:0]   tcol_r, tcol_nxt;
  logic [PW-1:0]   dot_r, dot_nxt;

  logic [PW-1:0]   col_p, col_dot, len_p, len_str;
  logic            again;
  logic [1:0]      pre_n;
  logic            post_v;
  result_t         pre0, pre1, post;
  token_kind_t     punct_kind;
  logic [RES_CNT_W-1:0] n_res;
  result_t [MAX_RES-1:0] items;

  // Columns and open-token lengths
  assign col_p   = sat_inc(sub0(pos_r, lstart_r));
  assign col_dot = sat_inc(sub0(dot_r, lstart_r));
  assign len_p   = sub0(pos_r, tstart_r);
  assign len_str = (pos_r > tstart_r) ? pos_r - tstart_r - 1'b1 : '0;

  // Map a single-byte punctuator
  always_comb begin
    unique case (byte_data)
      CH_LT:    punct_kind = TK_LT;
      CH_GT:    punct_kind = TK_GT;
      CH_BANG:  punct_kind = TK_BANG;
      CH_QUEST: punct_kind = TK_QUEST;
      CH_DASH:  punct_kind = TK_DASH;
      CH_SLASH: punct_kind = TK_SLASH;
      CH_EQ:    punct_kind = TK_EQ;
      default:  punct_kind = TK_ERROR;
    endcase
  end

  // Next state and tokens for the held byte
  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    lstart_nxt = lstart_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    dot_nxt    = dot_r;
    again      = 1'b0;
    pre_n      = 2'd0;
    post_v     = 1'b0;
    pre0       = '0;
    pre1       = '0;
    post       = '0;

    unique case (mode_r)
      M_IDENT: begin
        if (!ident_body(byte_data)) begin
          pre0  = mk(TK_IDENT, ERR_NONE, tstart_r, len_p, tline_r, tcol_r);
          pre_n = 2'd1;
          again = 1'b1;
        end
      end
      M_ZERO, M_DEC: begin
        if (mode_r == M_ZERO && (byte_data == CH_LX || byte_data == CH_UX)) begin
          mode_nxt = M_HEX;
        end else if (is_digit(byte_data)) begin
          mode_nxt = M_DEC;
        end else if (byte_data == CH_DOT) begin
          dot_nxt  = pos_r;
          mode_nxt = M_DOT;
        end else begin
          pre0  = mk(TK_NUMBER, ERR_NONE, tstart_r, len_p, tline_r, tcol_r);
          pre_n = 2'd1;
          again = 1'b1;
        end
      end
      M_HEX, M_FRAC: begin
        if (!((mode_r == M_HEX) ? is_hex(byte_data) : is_digit(byte_data))) begin
          pre0  = mk(TK_NUMBER, ERR_NONE, tstart_r, len_p, tline_r, tcol_r);
          pre_n = 2'd1;
          again = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(byte_data)) begin
          mode_nxt = M_FRAC;
        end else begin
          // Number ends before the held dot; the dot itself is an error
          pre0  = mk(TK_NUMBER, ERR_NONE, tstart_r, sub0(dot_r, tstart_r),
                     tline_r, tcol_r);
          pre1  = mk(TK_ERROR, ERR_UNEXPECTED, dot_r, PW'(1), line_r, col_dot);
          pre_n = 2'd2;
          again = 1'b1;
        end
      end
      M_STR, M_ESC: begin
        if (byte_data == CH_NUL) begin
          pre0  = mk(TK_ERROR, ERR_UNTERMINATED, tstart_r, len_p, tline_r, tcol_r);
          pre_n = 2'd1;
          again = 1'b1;
        end else if (mode_r == M_STR && byte_data == CH_QUOTE) begin
          pre0     = mk(TK_STRING, ERR_NONE, sat_inc(tstart_r), len_str, tline_r, tcol_r);
          pre_n    = 2'd1;
          mode_nxt = M_IDLE;
        end else begin
          if (byte_data == CH_LF) begin
            line_nxt   = sat_inc(line_r);
            lstart_nxt = sat_inc(pos_r);
          end
          mode_nxt = (mode_r == M_STR && byte_data == CH_BSL) ? M_ESC : M_STR;
        end
      end
      M_IDLE: again = 1'b1;
      default: again = 1'b1;
    endcase

    // Scan the byte afresh
    if (again) begin
      mode_nxt = M_IDLE;
      if (byte_data == CH_NUL) begin
        post   = mk(TK_END, ERR_NONE, pos_r, '0, line_r, col_p);
        post_v = 1'b1;
      end else if (byte_data == CH_SP || byte_data == CH_TAB || byte_data == CH_CR) begin
        mode_nxt = M_IDLE;
      end else if (byte_data == CH_LF) begin
        line_nxt   = sat_inc(line_r);
        lstart_nxt = sat_inc(pos_r);
      end else if (is_digit(byte_data) || ident_start(byte_data) ||
                   byte_data == CH_QUOTE) begin
        tstart_nxt = pos_r;
        tline_nxt  = line_r;
        tcol_nxt   = col_p;
        if (is_digit(byte_data)) begin
          mode_nxt = (byte_data == CH_ZERO) ? M_ZERO : M_DEC;
        end else if (byte_data == CH_QUOTE) begin
          mode_nxt = M_STR;
        end else begin
          mode_nxt = M_IDENT;
        end
      end else begin
        post   = mk(punct_kind, (punct_kind == TK_ERROR) ? ERR_UNEXPECTED : ERR_NONE,
                    pos_r, PW'(1), line_r, col_p);
        post_v = 1'b1;
      end
    end

    // Advance position, or restart counting on the end byte
    if (byte_data == CH_NUL) begin
      mode_nxt   = M_IDLE;
      pos_nxt    = '0;
      line_nxt   = PW'(1);
      lstart_nxt = '0;
    end else begin
      pos_nxt = sat_inc(pos_r);
    end
  end

  // Pack results in order and mark the final one
  always_comb begin
    n_res    = RES_CNT_W'(pre_n) + RES_CNT_W'(post_v);
    items[0] = (pre_n == 2'd0) ? post : pre0;
    items[1] = (pre_n == 2'd1) ? post : pre1;
    items[2] = post;
    if (n_res != '0) begin
      items[n_res - 1'b1].last = 1'b1;
    end
  end

  assign take       = byte_valid && (free_slots >= 3'(n_res));
  assign push.valid = take && (n_res != '0);
  assign push.cnt   = n_res;
  assign push.items = items;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      line_r   <= PW'(1);
      lstart_r <= '0;
      tstart_r <= '0;
      tline_r  <= PW'(1);
      tcol_r   <= PW'(1);
      dot_r    <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      lstart_r <= lstart_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
      dot_r    <= dot_nxt;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0 && tline_r != '0)
    else $error("line counter reached zero");

  a_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tcol_r != '0)
    else $error("token column reached zero");

  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && byte_data == CH_NUL) |=> (mode_r == M_IDLE && pos_r == '0 && line_r == PW'(1)))
    else $error("end byte did not restart position counting");

endmodule

// File: src/xtl_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtl_result_queue: token output queue
// Four-entry shift queue that takes up to three tokens per cycle and
// presents its head register as the output beat.
// ----------------------------------------------------------------------------
module xtl_result_queue import xtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  output logic [2:0]  free_slots,
  xtl_out_if.source   out_if
);

  localparam int DEPTH = 4;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t [DEPTH-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pop;
  logic [CNT_W-1:0]    base;
  logic [CNT_W-1:0]    rel [DEPTH];

  assign pop        = (cnt_r != '0) && out_if.ready;
  assign base       = cnt_r - CNT_W'(pop);
  assign free_slots = 3'(CNT_W'(DEPTH) - base);

  // Shift out the head, then append the new tokens
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      rel[i] = CNT_W'(i) - base;
      if (pop && i < DEPTH - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push.valid && CNT_W'(i) >= base && rel[i] < CNT_W'(push.cnt)) begin
        q_nxt[i] = push.items[rel[i][RES_CNT_W-1:0]];
      end
    end
    cnt_nxt = base + (push.valid ? CNT_W'(push.cnt) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // Drive the output beat from the head entry
  assign out_if.valid         = cnt_r != '0;
  assign out_if.token_kind    = q_r[0].token_kind;
  assign out_if.error_kind    = q_r[0].error_kind;
  assign out_if.start_offset  = q_r[0].start_offset;
  assign out_if.token_length  = q_r[0].token_length;
  assign out_if.line_number   = q_r[0].line_number;
  assign out_if.column_number = q_r[0].column_number;
  assign out_if.last          = q_r[0].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (4'(cnt_r) - 4'(pop) + 4'(push.cnt)) <= 4'(DEPTH))
    else $error("push overflows queue");

  a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (push.cnt != '0 && push.items[push.cnt - 1'b1].last))
    else $error("push without final-token mark");

endmodule

// File: src/xml_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_token_lexer: streaming XML token lexer
// Byte-in, token-out lexer: input register, scanner and output queue.
// Path: a byte's tokens enter the output queue when the scanner takes it.
// Throughput: one byte per cycle while out_if is ready and each byte gives
//   at most one token; a byte that closes a token and starts another output,
//   or a failed held dot (up to three tokens), is bounded by the
//   one-token-per-cycle output queue.
// Reset: synchronous active-low rst_n clears the queue, the input register
//   and the scan state (position 0, line 1, column 1); no clearing pass.
// ----------------------------------------------------------------------------
module xml_token_lexer import xtl_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  xtl_in_if.sink     in_if,
  xtl_out_if.source  out_if
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       take;
  logic [2:0] free_slots;
  push_t      push;

  // Hold the incoming byte
  xtl_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Scan it
  xtl_scanner #(
    .PW (POSITION_BITS)
  ) u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .free_slots (free_slots),
    .take       (take),
    .push       (push)
  );

  // Queue and present tokens
  xtl_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .free_slots (free_slots),
    .out_if     (out_if)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the XML token lexer
// Feeds text bytes through the input channel and checks every token against
// an in-bench lexer that tracks mode, position, line and column. A directed
// text covers each token kind and the corner cases; random fragments of
// identifiers, numbers, strings, punctuation, whitespace and noise follow.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb import xtl_pkg::*; ();

  localparam logic [7:0] CH_END    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam int RANDOM_BYTES = 278;
  localparam int MAX_REPORTS = 10;

  typedef logic [FIELD_W-1:0] pos_t;

  // Tracks the lexer state and holds the tokens still owed by the block
  class token_tracker;
    result_t     pending_tokens[$];
    result_t     fresh[$];
    int unsigned mismatches;
    mode_t       mode;
    pos_t        pos, line_no, line_base, tok_pos, tok_line, tok_col, dot_pos;

    function new();
      mismatches = 0;
      mode = M_IDLE;
      pos = '0;
      line_no = pos_t'(1);
      line_base = '0;
      tok_pos = '0;
      tok_line = pos_t'(1);
      tok_col = pos_t'(1);
      dot_pos = '0;
    endfunction

    function pos_t bump(input pos_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function pos_t col_at(input pos_t p);
      return bump((p >= line_base) ? p - line_base : '0);
    endfunction

    function bit is_dec(input logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_hexd(input logic [7:0] c);
      return is_dec(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function bit id_first(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             c == ":" || c == "_" || c >= 8'h80;
    endfunction

    function bit id_rest(input logic [7:0] c);
      return id_first(c) || c == "-" || c == "." || is_dec(c);
    endfunction

    function void add(input token_kind_t k, input err_kind_t e, input pos_t st,
                      input pos_t len, input pos_t ln, input pos_t cl);
      result_t r;
      r.token_kind = k;
      r.error_kind = e;
      r.start_offset = st;
      r.token_length = len;
      r.line_number = ln;
      r.column_number = cl;
      r.last = 1'b0;
      if (fresh.size() < MAX_RES) fresh.insert(fresh.size(), r);
    endfunction

    // Close the open token, ending just before stop
    function void close_token(input token_kind_t k, input pos_t stop);
      add(k, ERR_NONE, tok_pos, (stop >= tok_pos) ? stop - tok_pos : '0, tok_line, tok_col);
    endfunction

    function void start_token(input pos_t p, input mode_t m);
      tok_pos = p;
      tok_line = line_no;
      tok_col = col_at(p);
      mode = m;
    endfunction

    function void line_feed(input pos_t p);
      line_no = bump(line_no);
      line_base = bump(p);
    endfunction

    function token_kind_t punct_kind(input logic [7:0] c);
      case (c)
        "<": return TK_LT;
        ">": return TK_GT;
        "!": return TK_BANG;
        "?": return TK_QUEST;
        "-": return TK_DASH;
        "/": return TK_SLASH;
        "=": return TK_EQ;
        default: return TK_ERROR;
      endcase
    endfunction

    // Advance the lexer by one accepted byte and queue the tokens it yields
    function void lex_byte(input logic [7:0] b);
      pos_t        p;
      bit          rescan;
      token_kind_t k;
      p = pos;
      rescan = 1'b0;
      fresh.delete();
      case (mode)
        M_IDENT: begin
          if (!id_rest(b)) begin
            close_token(TK_IDENT, p);
            rescan = 1'b1;
          end
        end
        M_ZERO, M_DEC: begin
          if (mode == M_ZERO && (b == "x" || b == "X")) mode = M_HEX;
          else if (is_dec(b)) mode = M_DEC;
          else if (b == ".") begin
            dot_pos = p;
            mode = M_DOT;
          end else begin
            close_token(TK_NUMBER, p);
            rescan = 1'b1;
          end
        end
        M_HEX: begin
          if (!is_hexd(b)) begin
            close_token(TK_NUMBER, p);
            rescan = 1'b1;
          end
        end
        M_DOT: begin
          // A dot with no digit after it: number ends, dot is an error
          if (is_dec(b)) mode = M_FRAC;
          else begin
            close_token(TK_NUMBER, dot_pos);
            add(TK_ERROR, ERR_UNEXPECTED, dot_pos, pos_t'(1), line_no, col_at(dot_pos));
            rescan = 1'b1;
          end
        end
        M_FRAC: begin
          if (!is_dec(b)) begin
            close_token(TK_NUMBER, p);
            rescan = 1'b1;
          end
        end
        M_STR, M_ESC: begin
          if (b == CH_END) begin
            add(TK_ERROR, ERR_UNTERMINATED, tok_pos, (p >= tok_pos) ? p - tok_pos : '0,
                tok_line, tok_col);
            rescan = 1'b1;
          end else if (mode == M_STR && b == CH_QUOTE) begin
            add(TK_STRING, ERR_NONE, bump(tok_pos), (p > tok_pos) ? p - tok_pos - 1'b1 : '0,
                tok_line, tok_col);
            mode = M_IDLE;
          end else begin
            if (b == CH_LF) line_feed(p);
            mode = (mode == M_STR && b == CH_BSLASH) ? M_ESC : M_STR;
          end
        end
        default: rescan = 1'b1;
      endcase

      // Scan the byte afresh from idle
      if (rescan) begin
        mode = M_IDLE;
        if (b == CH_END) add(TK_END, ERR_NONE, p, '0, line_no, col_at(p));
        else if (b == " " || b == CH_TAB || b == CH_CR) begin
          // skip blanks
        end else if (b == CH_LF) line_feed(p);
        else if (is_dec(b)) start_token(p, (b == "0") ? M_ZERO : M_DEC);
        else if (id_first(b)) start_token(p, M_IDENT);
        else if (b == CH_QUOTE) start_token(p, M_STR);
        else begin
          k = punct_kind(b);
          add(k, (k == TK_ERROR) ? ERR_UNEXPECTED : ERR_NONE, p, pos_t'(1), line_no,
              col_at(p));
        end
      end

      // End of text restarts position counting
      if (b == CH_END) begin
        mode = M_IDLE;
        pos = '0;
        line_no = pos_t'(1);
        line_base = '0;
      end else begin
        pos = bump(p);
      end

      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) pending_tokens.insert(pending_tokens.size(), fresh[i]);
    endfunction

    // Compare one token beat with the oldest one owed
    function void match_token(input result_t got);
      result_t want;
      bit      bad;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected token kind %0d off %0d len %0d", $realtime,
                   got.token_kind, got.start_offset, got.token_length);
        return;
      end
      want = pending_tokens.pop_front();
      bad = got.token_kind !== want.token_kind || got.error_kind !== want.error_kind ||
            got.start_offset !== want.start_offset ||
            got.token_length !== want.token_length ||
            got.line_number !== want.line_number ||
            got.column_number !== want.column_number || got.last !== want.last;
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: token mismatch", $realtime);
          $display("  expected kind %0d err %0d off %0d len %0d line %0d col %0d last %0b",
                   want.token_kind, want.error_kind, want.start_offset, want.token_length,
                   want.line_number, want.column_number, want.last);
          $display("  actual   kind %0d err %0d off %0d len %0d line %0d col %0d last %0b",
                   got.token_kind, got.error_kind, got.start_offset, got.token_length,
                   got.line_number, got.column_number, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   stall_left;
  logic [7:0] script_q[$];
  token_tracker tracker = new();

  xtl_in_if  in_if ();
  xtl_out_if out_if ();

  xml_token_lexer #(.POSITION_BITS(FIELD_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length: mostly none, sometimes short, rarely long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stall the token channel at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = idle_span();
    end
  end

  function automatic result_t sample_token();
    result_t r;
    r.token_kind = token_kind_t'(out_if.token_kind);
    r.error_kind = err_kind_t'(out_if.error_kind);
    r.start_offset = out_if.start_offset;
    r.token_length = out_if.token_length;
    r.line_number = out_if.line_number;
    r.column_number = out_if.column_number;
    r.last = out_if.last;
    return r;
  endfunction

  // Track accepted bytes first, then check token beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tracker.lex_byte(in_if.text_byte);
      if (out_if.valid && out_if.ready) tracker.match_token(sample_token());
    end
  end

  // Present one byte and hold it until the beat is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.text_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic feed_script();
    while (script_q.size() > 0) send_byte(script_q.pop_front());
  endtask

  // Drop valid and hold off until every owed token has come out
  task automatic drain_tokens();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_tokens.size() != 0) @(negedge clk);
  endtask

  // Append one byte to the script
  function automatic void queue_byte(input logic [7:0] b);
    script_q.insert(script_q.size(), b);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_ident_char(input bit first);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h80, 8'hFF));
    return first ? pick_char("AMZamz:_Qk") : pick_char("AZaz:_-.09k5");
  endfunction

  // Queue one fragment with random content, sometimes malformed, or some noise
  function automatic void queue_fragment();
    logic [7:0] c;
    int n;
    n = $urandom_range(0, 5);
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        queue_byte(pick_ident_char(1'b1));
        repeat (n) queue_byte(pick_ident_char(1'b0));
      end
      3, 4: repeat (n + 1) queue_byte(pick_char("0123456789"));
      5: begin
        repeat (n % 3 + 1) queue_byte(pick_char("0123456789"));
        queue_byte(".");
        repeat (n % 4 + 1) queue_byte(pick_char("0123456789"));
      end
      6: begin
        queue_byte("0");
        queue_byte(pick_char("xX"));
        repeat (n) queue_byte(pick_char("0123456789abcdefABCDEF"));
      end
      7: begin
        repeat (n % 3 + 1) queue_byte(pick_char("0123456789"));
        queue_byte(".");
        queue_byte(pick_char("<.a x=\n"));
      end
      8, 9: begin
        queue_byte(CH_QUOTE);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            queue_byte(CH_BSLASH);
            queue_byte(8'($urandom_range(1, 255)));
          end else begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            queue_byte(c);
          end
        end
        queue_byte(($urandom_range(0, 7) == 0) ? CH_END : CH_QUOTE);
      end
      10, 11, 12: queue_byte(pick_char("<>!?-/="));
      13, 14, 15: repeat (n % 3 + 1) queue_byte(pick_char(" \t\015\n"));
      16, 17: queue_byte(8'($urandom_range(1, 255)));
      default: queue_byte(CH_END);
    endcase
  endfunction

  initial begin
    int  fed;
    bit  paused;
    in_if.valid = 1'b0;
    in_if.text_byte = 8'h00;
    out_if.ready = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed text: all punctuators, high-byte identifier, fraction, empty hex,
    // failed held dot, escaped quote and line feed, unterminated string at end
    push_text("<!?-/=>");
    queue_byte(8'hFF);
    push_text(".9\n\t1.5");
    queue_byte(CH_CR);
    push_text("0x=5.#\"\\\"\\\n\"\"\\");
    queue_byte(CH_END);
    feed_script();
    drain_tokens();

    // Random fragments, with one quiet stretch and one full drain midway
    fed = 0;
    paused = 1'b0;
    while (fed < RANDOM_BYTES) begin
      calm = (fed >= 60 && fed < 110);
      queue_fragment();
      fed += script_q.size();
      feed_script();
      if (!paused && fed >= RANDOM_BYTES / 2) begin
        drain_tokens();
        paused = 1'b1;
      end
    end
    calm = 1'b0;

    // Flush any open token and close out the run
    send_byte(CH_END);
    drain_tokens();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_tokens.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/xtl_pkg.sv
src/xtl_in_if.sv
src/xtl_out_if.sv
src/xtl_in_stage.sv
src/xtl_scanner.sv
src/xtl_result_queue.sv
src/xml_token_lexer.sv
tb/tb.sv
